// ===== src/nsd_pkg.sv =====
`default_nettype none

package nsd_pkg;

    // Width of the announced payload length.
    localparam int LEN_W = 16;
    // Accumulator holds one extra bit so it can saturate at 2^LEN_W.
    localparam int ACC_W = LEN_W + 1;
    // Width of the accumulator times ten plus one digit.
    localparam int MUL_W = LEN_W + 5;
    // Width used to compare the accumulator against the configured limit.
    localparam int CMP_W = 34;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

    // Result kinds carried on the output tuser.
    typedef enum logic [1:0] {
        KIND_BYTE = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    // Byte classes decided by the front part.
    typedef enum logic [1:0] {
        CLS_DIGIT = 2'd0,
        CLS_COLON = 2'd1,
        CLS_COMMA = 2'd2,
        CLS_OTHER = 2'd3
    } t_cls;

    typedef struct packed {
        logic [7:0] rx_byte;
        t_cls       cls;
    } t_item;

    // Handshake between the queue and the parser.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_q_out;

endpackage

`default_nettype wire

// ===== src/netstring_deframer_top.sv =====
`default_nettype none

// Channel     Dir  Handshake                    Payload
// s_axis      in   s_axis_tvalid/s_axis_tready   tdata[7:0] rx_byte
// m_axis      out  m_axis_tvalid/m_axis_tready   tdata: payload_byte, frame_length
//                                                tuser: kind
// apb         in   psel/penable/pwrite/pready    register 0 max_payload_length
//
// One byte is accepted per cycle whenever the four-entry queue has room; the
// parser drains one queued byte per cycle whenever its output register is free
// or is being taken, so the sustained rate is one item per cycle.
// When nothing stalls, an accepted byte passes through the queue memory and
// then the result register before its result is presented.
// Reset is synchronous and active low; it empties the queue, drops any pending
// result, returns the parser to length reading and sets the limit to 1024.
// A stall on the output backs up into the queue, and only a full queue lowers
// s_axis_tready.

module netstring_deframer_top (
    input  wire          i_clk,
    input  wire          i_rst_n,

    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // [7:0] rx_byte

    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [23:0]  m_axis_tdata,   // [7:0] payload_byte, [23:8] frame_length
    output logic [1:0]   m_axis_tuser,   // [1:0] kind

    input  wire          psel,
    input  wire          penable,
    input  wire          pwrite,
    input  wire  [2:0]   paddr,
    input  wire  [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import nsd_pkg::*;

    // Register index is the word address; only index zero exists.
    localparam logic REG_MAX_LEN = 1'b0;

    t_q_out        w_q;
    logic          w_pop;
    logic [15:0]   r_max_len;
    logic [7:0]    w_pay;
    logic [15:0]   w_flen;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN) begin
            r_max_len <= pwdata[15:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_MAX_LEN) begin
            prdata = 32'(r_max_len);
        end
    end

    // The front classifies each byte and queues it.
    nsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .o_q     (w_q),
        .i_pop   (w_pop)
    );

    // The back runs the framing state machine and holds the result register.
    nsd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q            (w_q),
        .o_pop          (w_pop),
        .i_max_len      (r_max_len),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_kind         (m_axis_tuser),
        .o_payload_byte (w_pay),
        .o_frame_length (w_flen)
    );

    assign m_axis_tdata = {w_flen, w_pay};

endmodule

`default_nettype wire

// ===== src/nsd_front.sv =====
`default_nettype none

module nsd_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_byte,
    output nsd_pkg::t_q_out     o_q,
    input  wire                 i_pop
);
    import nsd_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    t_item               w_item;
    logic                w_push;
    logic                w_pop;

    always_comb begin
        w_item.rx_byte = i_byte;
        if (i_byte >= CH_ZERO && i_byte <= CH_NINE) begin
            w_item.cls = CLS_DIGIT;
        end else if (i_byte == CH_COLON) begin
            w_item.cls = CLS_COLON;
        end else if (i_byte == CH_COMMA) begin
            w_item.cls = CLS_COMMA;
        end else begin
            w_item.cls = CLS_OTHER;
        end
    end

    assign o_ready    = (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign w_push     = i_valid && o_ready;
    assign o_q.valid  = (r_count != '0);
    assign o_q.item   = r_mem[r_rd_ptr];
    assign w_pop      = i_pop && o_q.valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/nsd_back.sv =====
`default_nettype none

module nsd_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  nsd_pkg::t_q_out     i_q,
    output logic                o_pop,
    input  wire  [15:0]         i_max_len,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [1:0]          o_kind,
    output logic [7:0]          o_payload_byte,
    output logic [15:0]         o_frame_length
);
    import nsd_pkg::*;

    typedef enum logic [2:0] {
        ST_LEN   = 3'b001,
        ST_PAY   = 3'b010,
        ST_COMMA = 3'b100
    } t_state;

    localparam logic [ACC_W-1:0] CAP = {1'b0, {LEN_W{1'b1}}};
    localparam logic [ACC_W-1:0] SAT = {1'b1, {LEN_W{1'b0}}};

    t_state              r_state, n_state;
    logic [ACC_W-1:0]    r_len, n_len;
    logic                r_seen, n_seen;
    logic [LEN_W-1:0]    r_rem, n_rem;
    logic                r_valid;
    t_kind               r_kind;
    logic [7:0]          r_pay;
    logic [15:0]         r_flen;

    logic                w_emit;
    t_kind               w_kind;
    logic [7:0]          w_pay;
    logic [15:0]         w_flen;
    logic [MUL_W-1:0]    w_acc;
    logic                w_in_limit;

    // A queued byte is parsed whenever the output register is free or drains.
    assign o_pop = i_q.valid && (!r_valid || i_ready);

    assign w_acc = (MUL_W'(r_len) << 3) + (MUL_W'(r_len) << 1)
                 + MUL_W'(i_q.item.rx_byte[3:0]);
    assign w_in_limit = (CMP_W'(r_len) <= CMP_W'(i_max_len)) && (r_len <= CAP);

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_seen  = r_seen;
        n_rem   = r_rem;
        w_emit  = 1'b0;
        w_kind  = KIND_BYTE;
        w_pay   = '0;
        w_flen  = '0;
        unique case (r_state)
            ST_PAY: begin
                w_emit = 1'b1;
                w_pay  = i_q.item.rx_byte;
                n_rem  = r_rem - LEN_W'(1);
                if (r_rem == LEN_W'(1)) begin
                    n_state = ST_COMMA;
                end
            end
            ST_COMMA: begin
                w_emit  = 1'b1;
                n_state = ST_LEN;
                n_len   = '0;
                n_seen  = 1'b0;
                n_rem   = '0;
                if (i_q.item.cls == CLS_COMMA) begin
                    w_kind = KIND_DONE;
                    w_flen = 16'(r_len);
                end else begin
                    w_kind = KIND_ERR;
                end
            end
            default: begin
                n_state = ST_LEN;
                if (i_q.item.cls == CLS_DIGIT) begin
                    n_len  = (w_acc > MUL_W'(SAT)) ? SAT : ACC_W'(w_acc);
                    n_seen = 1'b1;
                end else if (i_q.item.cls == CLS_COLON && r_seen && w_in_limit) begin
                    if (r_len == '0) begin
                        n_state = ST_COMMA;
                    end else begin
                        n_state = ST_PAY;
                        n_rem   = r_len[LEN_W-1:0];
                    end
                end else begin
                    // Malformed length field: report and start over.
                    w_emit = 1'b1;
                    w_kind = KIND_ERR;
                    n_len  = '0;
                    n_seen = 1'b0;
                    n_rem  = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LEN;
            r_len   <= '0;
            r_seen  <= 1'b0;
            r_rem   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_state <= n_state;
                r_len   <= n_len;
                r_seen  <= n_seen;
                r_rem   <= n_rem;
                r_valid <= w_emit;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_kind <= w_kind;
            r_pay  <= w_pay;
            r_flen <= w_flen;
        end
    end

    assign o_valid        = r_valid;
    assign o_kind         = r_kind;
    assign o_payload_byte = r_pay;
    assign o_frame_length = r_flen;

endmodule

`default_nettype wire
